// File: sv/cpp_pkg.sv
// ----------------------------------------------------------------------------
// cpp_pkg
// Shared types, constants and the CRC-8 update function for the controller
// packet parser.
// ----------------------------------------------------------------------------
`default_nettype none

package cpp_pkg;

	localparam logic [7:0] CRC_POLY   = 8'h07;
	localparam logic [7:0] SIGN_BIT   = 8'h80;
	localparam logic [7:0] HDR_RIGHT  = 8'hf0;
	localparam logic [7:0] HDR_LEFT   = 8'hf1;
	localparam logic [7:0] CRC_INIT   = 8'h00;

	localparam int POS_W      = 6;
	localparam int POS_LIMIT  = 36;
	localparam int POSE_START = 8;
	localparam int FIFO_DEPTH = 4;

	localparam logic [3:0] FID_HEADER    = 4'd0;
	localparam logic [3:0] FID_FUNC      = 4'd1;
	localparam logic [3:0] FID_POSE_BASE = 4'd8;
	localparam logic [3:0] FID_STATUS    = 4'd15;

	typedef enum logic [1:0] {
		HAND_RIGHT = 2'd0,
		HAND_LEFT  = 2'd1,
		HAND_OTHER = 2'd2
	} hand_side_t;

	typedef struct packed {
		logic [3:0]         field_id;
		logic signed [31:0] field_value;
		logic [1:0]         hand_side;
		logic               crc_ok;
		logic               end_of_packet;
	} cpp_result_t;

	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if ((c & SIGN_BIT) != 8'h00) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// File: sv/cpp_in_if.sv
// ----------------------------------------------------------------------------
// cpp_in_if
// Byte request channel into the controller packet parser.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

`default_nettype wire

// File: sv/cpp_out_if.sv
// ----------------------------------------------------------------------------
// cpp_out_if
// Parsed field request channel out of the controller packet parser.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpp_out_if;
	logic               valid;
	logic               ready;
	logic [3:0]         field_id;
	logic signed [31:0] field_value;
	logic [1:0]         hand_side;
	logic               crc_ok;
	logic               end_of_packet;

	modport source (output valid, output field_id, output field_value, output hand_side,
		output crc_ok, output end_of_packet, input ready);
	modport sink   (input valid, input field_id, input field_value, input hand_side,
		input crc_ok, input end_of_packet, output ready);
endinterface

`default_nettype wire

// File: sv/controller_packet_parser_crc8.sv
// ----------------------------------------------------------------------------
// controller_packet_parser_crc8
// Parses a controller packet byte by byte into fields and checks its CRC-8.
// ----------------------------------------------------------------------------
// Packet bytes arrive on pkt_in, one request per byte, with final_byte set on
// the last byte, which carries the CRC. Parsed fields leave on fld_out as soon
// as their last byte is taken: header, function, six button and stick values,
// seven 32-bit pose words, and a status request on the final byte that holds
// the computed CRC, the match flag and end_of_packet.
// A field enters a four-entry result queue when the byte that completes it is
// accepted and is offered on fld_out from there. The parser takes one byte per cycle
// while pkt_in.ready is high; the final byte may raise two requests, which the
// output drains at one per cycle while fld_out.ready is high. pkt_in.ready is
// high while at least two queue entries are free, so a stalled receiver holds
// the input back after the queue fills and no result is lost.
// Reset clears the byte position, the CRC, the word accumulator and the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module controller_packet_parser_crc8
	import cpp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	cpp_in_if.sink     pkt_in,
	cpp_out_if.source  fld_out
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = PTR_W + 1;

	logic [POS_W-1:0] pos_q;
	logic [7:0]       crc_q;
	logic [23:0]      acc_q;

	cpp_result_t      fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	logic             accept;
	logic             pop;
	logic [7:0]       b;
	logic             field_hit;
	cpp_result_t      field_res;
	cpp_result_t      status_res;
	logic [POS_W-1:0] pos_m8;
	logic [1:0]       push_cnt;

	assign accept = pkt_in.valid & pkt_in.ready;
	assign pop    = fld_out.valid & fld_out.ready;
	assign b      = pkt_in.data_byte;
	assign pos_m8 = pos_q - POS_W'(POSE_START);

	always_comb begin
		field_hit = 1'b0;
		field_res = '0;
		if (pos_q == '0) begin
			field_hit             = 1'b1;
			field_res.field_id    = FID_HEADER;
			field_res.field_value = {24'h000000, b};
			if (b == HDR_RIGHT) begin
				field_res.hand_side = HAND_RIGHT;
			end else if (b == HDR_LEFT) begin
				field_res.hand_side = HAND_LEFT;
			end else begin
				field_res.hand_side = HAND_OTHER;
			end
		end else if (pos_q == POS_W'(1)) begin
			field_hit             = 1'b1;
			field_res.field_id    = FID_FUNC;
			field_res.field_value = {24'h000000, b};
		end else if (pos_q < POS_W'(POSE_START)) begin
			field_hit             = 1'b1;
			field_res.field_id    = pos_q[3:0];
			field_res.field_value = {{24{b[7]}}, b};
		end else if (pos_q < POS_W'(POS_LIMIT) && pos_m8[1:0] == 2'd3) begin
			field_hit             = 1'b1;
			field_res.field_id    = FID_POSE_BASE + 4'(pos_m8[POS_W-1:2]);
			field_res.field_value = {b, acc_q};
		end
	end

	always_comb begin
		status_res               = '0;
		status_res.field_id      = FID_STATUS;
		status_res.field_value   = {24'h000000, crc_q};
		status_res.crc_ok        = (b == crc_q);
		status_res.end_of_packet = 1'b1;
	end

	assign push_cnt = accept ? (2'(field_hit) + 2'(pkt_in.final_byte)) : 2'd0;

	assign pkt_in.ready = (cnt_q <= CNT_W'(FIFO_DEPTH - 2));

	assign fld_out.valid         = (cnt_q != '0);
	assign fld_out.field_id      = fifo_q[rd_ptr_q].field_id;
	assign fld_out.field_value   = fifo_q[rd_ptr_q].field_value;
	assign fld_out.hand_side     = fifo_q[rd_ptr_q].hand_side;
	assign fld_out.crc_ok        = fifo_q[rd_ptr_q].crc_ok;
	assign fld_out.end_of_packet = fifo_q[rd_ptr_q].end_of_packet;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			crc_q <= CRC_INIT;
			acc_q <= '0;
		end else if (accept) begin
			if (pkt_in.final_byte) begin
				pos_q <= '0;
				crc_q <= CRC_INIT;
				acc_q <= '0;
			end else begin
				crc_q <= crc8_update(crc_q, b);
				if (pos_q < POS_W'(POS_LIMIT)) begin
					pos_q <= pos_q + POS_W'(1);
				end
				if (pos_q >= POS_W'(POSE_START) && pos_q < POS_W'(POS_LIMIT)) begin
					case (pos_m8[1:0])
						2'd0: acc_q <= {16'h0000, b};
						2'd1: acc_q[15:8] <= b;
						2'd2: acc_q[23:16] <= b;
						default: acc_q <= acc_q;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (field_hit) begin
				fifo_q[wr_ptr_q] <= field_res;
				if (pkt_in.final_byte) begin
					fifo_q[wr_ptr_q + PTR_W'(1)] <= status_res;
				end
			end else if (pkt_in.final_byte) begin
				fifo_q[wr_ptr_q] <= status_res;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(push_cnt) - CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

// File: sv/cpp_chk.sv
// ----------------------------------------------------------------------------
// cpp_chk
// Port-level checks for the controller packet parser, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cpp_chk
	import cpp_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [3:0]  field_id,
	input wire logic [1:0]  hand_side,
	input wire logic        crc_ok,
	input wire logic        end_of_packet
);

	// A stalled request stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output request dropped while stalled");

	// Only the status request closes a packet.
	a_eop_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_packet |-> field_id == FID_STATUS)
		else $error("end_of_packet on a non-status field");

	// Status requests always close the packet; other fields never report a match.
	a_status_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && field_id == FID_STATUS |-> end_of_packet)
		else $error("status field without end_of_packet");

	a_crc_ok_scope: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && field_id != FID_STATUS |-> !crc_ok)
		else $error("crc_ok set on a non-status field");

	// The hand side is only reported on the header field.
	a_hand_scope: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && field_id != FID_HEADER |-> hand_side == HAND_RIGHT)
		else $error("hand_side set on a non-header field");

endmodule

bind controller_packet_parser_crc8 cpp_chk u_cpp_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (fld_out.valid),
	.out_ready     (fld_out.ready),
	.field_id      (fld_out.field_id),
	.hand_side     (fld_out.hand_side),
	.crc_ok        (fld_out.crc_ok),
	.end_of_packet (fld_out.end_of_packet)
);

`default_nettype wire
